[sv/nal_length_prefix_to_start_code_core_defines.svh]
// ----------------------------------------------------------------------------
// nal_length_prefix_to_start_code_core_defines
// assertion macros shared by the converter core
// ----------------------------------------------------------------------------
`ifndef NAL_LENGTH_PREFIX_TO_START_CODE_CORE_DEFINES_SVH
`define NAL_LENGTH_PREFIX_TO_START_CODE_CORE_DEFINES_SVH

// same-cycle implication, checked on clk_i, off during reset
`define NLPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off during reset
`define NLPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/nlpsc_pkg.sv]
// ----------------------------------------------------------------------------
// nlpsc_pkg
// shared types and constants of the length-prefix to start-code converter
// ----------------------------------------------------------------------------
package nlpsc_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SIZE_W   = 3;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // prefix size codes, anything else is pass-through
  localparam logic [SIZE_W-1:0] PREFIX_TWO   = 3'd2;
  localparam logic [SIZE_W-1:0] PREFIX_THREE = 3'd3;
  localparam logic [SIZE_W-1:0] PREFIX_FOUR  = 3'd4;
  localparam logic [SIZE_W-1:0] PREFIX_RESET = PREFIX_FOUR;

  // register index of prefix_size
  localparam logic REG_PREFIX_SIZE = 1'b0;

  // saturated length for oversized prefixes
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // start code bytes
  localparam logic [BYTE_W-1:0] SC_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] SC_ONE  = 8'h01;

  // one or two output bytes caused by one input byte
  typedef struct packed {
    logic              two;
    logic [BYTE_W-1:0] first_byte;
    logic              first_last;
    logic [BYTE_W-1:0] second_byte;
    logic              second_last;
  } nlpsc_pair_t;

  function automatic logic is_prefix_mode(input logic [SIZE_W-1:0] sz);
    is_prefix_mode = (sz == PREFIX_TWO) || (sz == PREFIX_THREE) || (sz == PREFIX_FOUR);
  endfunction

endpackage

[sv/nlpsc_in_if.sv]
// ----------------------------------------------------------------------------
// nlpsc_in_if
// input beat channel: one packet byte with its end mark
// ----------------------------------------------------------------------------
interface nlpsc_in_if;
  import nlpsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

[sv/nlpsc_out_if.sv]
// ----------------------------------------------------------------------------
// nlpsc_out_if
// output beat channel: one start-code-delimited byte with its last mark
// ----------------------------------------------------------------------------
interface nlpsc_out_if;
  import nlpsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

[sv/nlpsc_parser.sv]
// ----------------------------------------------------------------------------
// nlpsc_parser
// input register, prefix/payload tracking and start-code generation
// ----------------------------------------------------------------------------
module nlpsc_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [nlpsc_pkg::SIZE_W-1:0]  prefix_size_i,
  nlpsc_in_if.sink                      in_i,
  output logic                          push_o,
  output nlpsc_pkg::nlpsc_pair_t        pair_o,
  input  logic                          push_ready_i
);
  import nlpsc_pkg::*;

  logic              vld_q, vld_d;
  logic [BYTE_W-1:0] byte_q;
  logic              end_q;
  logic [SIZE_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0]  gather_q, gather_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              in_fire;
  logic              final_byte;
  logic [LEN_W-1:0]  gather_next;

  // input register takes a beat when empty or draining
  assign in_i.ready = !vld_q || push_ready_i;
  assign in_fire    = in_i.valid && in_i.ready;
  assign push_o     = vld_q && push_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (in_fire) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= in_i.data_byte;
      end_q  <= in_i.packet_end;
    end
  end

  // prefix byte decode
  assign final_byte  = pos_q >= (prefix_size_i - 3'd1);
  assign gather_next = (gather_q[LEN_W-1:LEN_W-BYTE_W] != '0) ? LEN_SAT
                     : {gather_q[LEN_W-BYTE_W-1:0], byte_q};

  // result bytes for the registered beat
  always_comb begin
    pair_o.two         = 1'b0;
    pair_o.first_byte  = byte_q;
    pair_o.first_last  = end_q;
    pair_o.second_byte = byte_q;
    pair_o.second_last = end_q;
    if (is_prefix_mode(prefix_size_i) && (left_q == '0)) begin
      if (prefix_size_i == PREFIX_TWO) begin
        pair_o.two         = 1'b1;
        pair_o.first_byte  = SC_ZERO;
        pair_o.first_last  = 1'b0;
        pair_o.second_byte = final_byte ? SC_ONE : SC_ZERO;
      end else begin
        pair_o.first_byte  = final_byte ? SC_ONE : SC_ZERO;
      end
    end
  end

  // parser state update
  always_comb begin
    pos_d    = pos_q;
    gather_d = gather_q;
    left_d   = left_q;
    if (is_prefix_mode(prefix_size_i)) begin
      if (left_q != '0) begin
        left_d = left_q - 24'd1;
      end else if (final_byte) begin
        left_d   = gather_next;
        gather_d = '0;
        pos_d    = '0;
      end else begin
        gather_d = gather_next;
        pos_d    = pos_q + 3'd1;
      end
    end
    if (end_q) begin
      pos_d    = '0;
      gather_d = '0;
      left_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      gather_q <= '0;
      left_q   <= '0;
    end else if (push_o) begin
      pos_q    <= pos_d;
      gather_q <= gather_d;
      left_q   <= left_d;
    end
  end

endmodule

[sv/nlpsc_out_queue.sv]
// ----------------------------------------------------------------------------
// nlpsc_out_queue
// two-entry result queue that sends each entry out one byte per beat
// ----------------------------------------------------------------------------
module nlpsc_out_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  nlpsc_pkg::nlpsc_pair_t  pair_i,
  output logic                    push_ready_o,
  nlpsc_out_if.source             out_o
);
  import nlpsc_pkg::*;

  nlpsc_pair_t entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        sub_q, sub_d;
  nlpsc_pair_t head;
  logic        out_fire;
  logic        pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign head         = entry_q[rd_ptr_q];

  // output beat from the head entry
  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = sub_q ? head.second_byte : head.first_byte;
  assign out_o.out_last = sub_q ? head.second_last : head.first_last;
  assign out_fire       = out_o.valid && out_o.ready;
  assign pop            = out_fire && (!head.two || sub_q);

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
    sub_d = sub_q;
    if (pop) begin
      sub_d = 1'b0;
    end else if (out_fire) begin
      sub_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sub_q    <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sub_q <= sub_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= pair_i;
    end
  end

endmodule

[sv/nal_length_prefix_to_start_code_core.sv]
// Path: an accepted byte is held in the parser's input register, and its result
//   is then written to the two-entry queue, whose head drives the output beat.
// Throughput: one input byte per cycle without back-pressure; in two-byte mode
//   a prefix byte takes two beats of the single output port draining the queue.
// Reset: asynchronous, active low; clears parser state and queue, prefix_size = 4.
// ----------------------------------------------------------------------------
// nal_length_prefix_to_start_code_core
// replaces big-endian NAL length prefixes by Annex B start codes
// ----------------------------------------------------------------------------
`include "nal_length_prefix_to_start_code_core_defines.svh"

module nal_length_prefix_to_start_code_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nlpsc_in_if.sink                      in_i,
  nlpsc_out_if.source                   out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nlpsc_pkg::APB_AW-1:0]  paddr,
  input  logic [nlpsc_pkg::APB_DW-1:0]  pwdata,
  output logic [nlpsc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import nlpsc_pkg::*;

  logic [SIZE_W-1:0] prefix_size_q;
  logic              cfg_wr;
  logic              push;
  logic              push_ready;
  nlpsc_pair_t       pair;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PREFIX_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_size_q <= PREFIX_RESET;
    end else if (cfg_wr) begin
      prefix_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PREFIX_SIZE)
                ? {{(APB_DW-SIZE_W){1'b0}}, prefix_size_q} : '0;

  // parser stage
  nlpsc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prefix_size_i(prefix_size_q),
    .in_i         (in_i),
    .push_o       (push),
    .pair_o       (pair),
    .push_ready_i (push_ready)
  );

  // result queue
  nlpsc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pair_i      (pair),
    .push_ready_o(push_ready),
    .out_o       (out_o)
  );

  // checks
  `NLPSC_ASSERT_NOW(a_pass_single, push && !is_prefix_mode(prefix_size_q),
                    !pair.two, "pass-through gave two bytes")
  `NLPSC_ASSERT_NOW(a_two_lead_zero, push && pair.two,
                    (pair.first_byte == SC_ZERO) && !pair.first_last,
                    "bad leading start-code byte")
  `NLPSC_ASSERT_NEXT(a_push_visible, push, out_o.valid,
                     "pushed result not visible at output")

endmodule

[tb/sv/nlpsc_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nlpsc_tb_pkg
// predictor and scoreboard for the length-prefix to start-code converter:
// tracks the prefix parser per accepted input beat and keeps the expected
// output beats in order
// ----------------------------------------------------------------------------
package nlpsc_tb_pkg;
  import nlpsc_pkg::*;

  // prefix_size codes that select pass-through
  localparam logic [SIZE_W-1:0] PASS_ZERO  = 3'd0;
  localparam logic [SIZE_W-1:0] PASS_ONE   = 3'd1;
  localparam logic [SIZE_W-1:0] PASS_FIVE  = 3'd5;
  localparam logic [SIZE_W-1:0] PASS_SEVEN = 3'd7;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_beat_t;

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  class start_code_predictor;
    logic [SIZE_W-1:0] prefix_size;
    logic [2:0]        prefix_pos;
    logic [LEN_W-1:0]  len_gather;
    logic [LEN_W-1:0]  payload_left;
    out_beat_t         expected_beats[$];
    int unsigned       mismatch_count;

    function new();
      prefix_size    = PREFIX_RESET;
      mismatch_count = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      prefix_pos   = '0;
      len_gather   = '0;
      payload_left = '0;
    endfunction

    function void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void expect_beat(logic [BYTE_W-1:0] data, logic last);
      out_beat_t beat;
      beat.data = data;
      beat.last = last;
      expected_beats.push_back(beat);
    endfunction

    // one accepted input beat gives one or two expected output beats
    function void take_input(logic [BYTE_W-1:0] data, logic pkt_end);
      logic              final_prefix;
      logic [BYTE_W-1:0] code_byte;
      if (!(prefix_size inside {PREFIX_TWO, PREFIX_THREE, PREFIX_FOUR})) begin
        expect_beat(data, pkt_end);
      end else if (payload_left != '0) begin
        expect_beat(data, pkt_end);
        payload_left = payload_left - 1'b1;
      end else begin
        // a position at or past the last one of the current size closes the prefix
        final_prefix = (int'(prefix_pos) >= int'(prefix_size) - 1);
        code_byte    = final_prefix ? SC_ONE : SC_ZERO;
        if (prefix_size == PREFIX_TWO) begin
          expect_beat(SC_ZERO, 1'b0);
        end
        expect_beat(code_byte, pkt_end);
        // a length that no longer fits in 24 bits saturates
        if (len_gather[LEN_W-1:16] != '0) begin
          len_gather = LEN_SAT;
        end else begin
          len_gather = {len_gather[LEN_W-9:0], data};
        end
        if (final_prefix) begin
          payload_left = len_gather;
          len_gather   = '0;
          prefix_pos   = '0;
        end else begin
          prefix_pos = prefix_pos + 1'b1;
        end
      end
      if (pkt_end) clear_parser();
    endfunction

    // compare one output beat with the oldest expected one
    function void check_beat(logic [BYTE_W-1:0] data, logic last);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat byte=%02h last=%0b", data, last));
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want.data) begin
        note_mismatch($sformatf("out_byte expected %02h actual %02h", want.data, data));
      end
      if (last !== want.last) begin
        note_mismatch($sformatf("out_last expected %0b actual %0b (byte %02h)",
                                want.last, last, want.data));
      end
    endfunction
  endclass

endpackage

[tb/sv/nal_length_prefix_to_start_code_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nal_length_prefix_to_start_code_core_tb
// drives packets of length-prefixed NAL units through the converter in all
// prefix sizes and pass-through, with random gaps and back-pressure, and
// checks every output beat against a cycle-free predictor
// ----------------------------------------------------------------------------
module nal_length_prefix_to_start_code_core_tb;
  import nlpsc_pkg::*;
  import nlpsc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned NUM_PHASES   = 11;
  localparam logic [APB_AW-1:0] ADDR_PREFIX_SIZE = APB_AW'(4 * REG_PREFIX_SIZE);

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  nlpsc_in_if  in_if ();
  nlpsc_out_if out_if ();

  start_code_predictor annexb_pred = new();

  int unsigned       bytes_sent;
  bit                in_idling;
  bit                out_stalling;
  bit                hold_request;
  logic [SIZE_W-1:0] phase_sizes [NUM_PHASES];

  nal_length_prefix_to_start_code_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("nal_length_prefix_to_start_code_core_tb failed");
    $finish;
  end

  // output side: random stalls, plus a long hold on each request
  initial begin : out_ready_drive
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_request = 1'b0;
      end
      stall = out_stalling ? pick_gap() : 0;
      if (stall == 0) begin
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      annexb_pred.check_beat(out_if.out_byte, out_if.out_last);
    end
  end

  // one input beat, called and returning at a falling edge
  task automatic send_beat(input logic [BYTE_W-1:0] data, input logic pkt_end);
    int unsigned gap;
    gap = in_idling ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      = 1'b1;
    in_if.data_byte  = data;
    in_if.packet_end = pkt_end;
    do @(posedge clk_i); while (!in_if.ready);
    annexb_pred.take_input(data, pkt_end);
    bytes_sent++;
    // back-pressure while the sender keeps offering
    if (bytes_sent % 300 == 150) hold_request = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] pkt[$], input logic with_end);
    foreach (pkt[i]) send_beat(pkt[i], with_end && (i == pkt.size() - 1));
  endtask

  // wait until every expected beat has come out
  task automatic settle();
    in_if.valid = 1'b0;
    while (annexb_pred.expected_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // register write and read-back while the core is idle
  task automatic write_prefix_size(input logic [SIZE_W-1:0] value);
    settle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_PREFIX_SIZE;
    pwdata  = APB_DW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    annexb_pred.prefix_size = value;
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DW'(value)) begin
      annexb_pred.note_mismatch($sformatf("prdata expected %08h actual %08h",
                                          APB_DW'(value), prdata));
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // mostly well-formed unit chains, some cut short, some noise
  task automatic send_random_packet(input logic [SIZE_W-1:0] mode);
    logic [BYTE_W-1:0] pkt[$];
    int unsigned       kind;
    int unsigned       width;
    int unsigned       len;
    int unsigned       cut;
    kind  = $urandom_range(0, 99);
    width = (mode inside {PREFIX_TWO, PREFIX_THREE, PREFIX_FOUR}) ?
            int'(mode) : $urandom_range(2, 4);
    if (kind < 80) begin
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        for (int k = width - 1; k >= 0; k--) pkt.push_back(BYTE_W'(len >> (8 * k)));
        repeat (len) pkt.push_back(BYTE_W'($urandom));
      end
      // stop inside a prefix or a payload
      if (kind >= 68) begin
        cut = $urandom_range(0, pkt.size() - 1);
        pkt = pkt[0:cut];
      end
    end else begin
      // random bytes, which read as long or oversized lengths
      repeat ($urandom_range(1, 12)) pkt.push_back(BYTE_W'($urandom));
    end
    send_packet(pkt, 1'b1);
  endtask

  // main sequence
  initial begin : stimulus
    logic [BYTE_W-1:0] pkt[$];
    int unsigned       phase_end;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.packet_end = 1'b0;
    bytes_sent       = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // unit, zero-length unit, packet ending inside a prefix
    pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hAA,
            8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00};
    send_packet(pkt, 1'b1);
    // oversized four-byte length saturates, rest is payload
    pkt = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h7F};
    send_packet(pkt, 1'b1);
    // size change in the middle of a prefix
    pkt = '{8'h00, 8'h00, 8'h00};
    send_packet(pkt, 1'b0);
    write_prefix_size(PREFIX_TWO);
    pkt = '{8'h03, 8'hFF, 8'h00, 8'h5A};
    send_packet(pkt, 1'b1);

    // random phases over all sizes and pass-through codes
    phase_sizes = '{PREFIX_FOUR, PREFIX_THREE, PREFIX_TWO, PASS_ZERO, PREFIX_TWO, PASS_ONE,
                    PREFIX_THREE, PASS_FIVE, PREFIX_FOUR, PASS_SEVEN, PREFIX_TWO};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_prefix_size(phase_sizes[p]);
      in_idling    = (p % 3 != 0);
      out_stalling = in_idling;
      phase_end    = bytes_sent +
                     ((phase_sizes[p] inside {PREFIX_TWO, PREFIX_THREE, PREFIX_FOUR}) ? 75 : 25);
      while (bytes_sent < phase_end) send_random_packet(phase_sizes[p]);
      // sometimes leave a packet open across the next register write
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 3)) send_beat(8'h00, 1'b0);
      end
    end

    settle();
    if (annexb_pred.mismatch_count == 0 && annexb_pred.expected_beats.size() == 0) begin
      $display("nal_length_prefix_to_start_code_core_tb passed");
    end else begin
      $display("nal_length_prefix_to_start_code_core_tb failed");
    end
    $finish;
  end

endmodule
